>>> rtl/ghbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_pkg
// Shared constants, operation codes and index helpers for the global-history
// branch predictor.
// ----------------------------------------------------------------------------
package ghbp_pkg;

  localparam int TABLE_ENTRIES  = 4096;
  localparam int HISTORY_BITS   = 12;
  localparam int INFLIGHT_SLOTS = 256;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W = $clog2(INFLIGHT_SLOTS);
  localparam int TAG_W  = 6;
  localparam int PIECE_W = 2;
  localparam int KEY_W  = TAG_W + PIECE_W;
  localparam int CNT_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MIN = 2'd0;

  typedef logic [HISTORY_BITS-1:0] hist_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_SPEC    = 2'd1,
    OP_TRAIN   = 2'd2,
    OP_COMMIT  = 2'd3
  } op_t;

  // History modulo table size; zero-extend first so either side may be wider.
  function automatic idx_t table_index(hist_t hist);
    logic [HISTORY_BITS+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, hist};
    return wide[IDX_W-1:0];
  endfunction

  // Checkpoint slot: {tag, piece} modulo slot count.
  function automatic slot_t slot_of(logic [TAG_W-1:0] tag, logic [PIECE_W-1:0] piece);
    logic [KEY_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, tag, piece};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

>>> rtl/ghbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_if
// Valid/ready channels: branch operation requests in, prediction results out.
// ----------------------------------------------------------------------------
interface ghbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] seq_tag;
  logic [1:0] piece_num;
  logic       taken;

  modport source (output valid, operation, seq_tag, piece_num, taken, input ready);
  modport sink   (input valid, operation, seq_tag, piece_num, taken, output ready);
endinterface

interface ghbp_out_if;
  logic valid;
  logic ready;
  logic predict_taken;
  logic checkpoint_missing;

  modport source (output valid, predict_taken, checkpoint_missing, input ready);
  modport sink   (input valid, predict_taken, checkpoint_missing, output ready);
endinterface

>>> rtl/ghbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ghbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/global_history_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// global_history_branch_predictor
// GAg predictor: global history register, 2-bit counter table in RAM and a
// checkpoint RAM of history per in-flight branch slot.
// Timing: speculative update, commit and train-without-checkpoint register
//   their result in the cycle after the request; predict reads the counter
//   RAM, then registers the result; train reads the checkpoint, then the
//   counter, then writes the counter back as it registers the result.
// One request in flight. Reset clears history and checkpoint valid bits at
//   once, then sweeps all TABLE_ENTRIES (4096) counters to zero, taking no request.
// ----------------------------------------------------------------------------
module global_history_branch_predictor (
  input  logic              clk,
  input  logic              rst,
  ghbp_in_if.sink           in_ch,
  ghbp_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CNT
  } state_t;

  state_t                 state;
  ghbp_pkg::idx_t         clr_addr;
  ghbp_pkg::hist_t        history;
  logic                   valid_bits [ghbp_pkg::INFLIGHT_SLOTS];
  logic                   is_train;
  logic                   cur_dir;
  ghbp_pkg::idx_t         cur_idx;
  logic                   out_valid;
  logic                   out_pred;
  logic                   out_miss;

  ghbp_pkg::op_t          in_op;
  ghbp_pkg::slot_t        in_slot;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;

  ghbp_pkg::hist_t        ck_rdata;
  logic                   ck_we;
  ghbp_pkg::cnt_t         cnt_rdata;
  ghbp_pkg::cnt_t         cnt_wdata;
  ghbp_pkg::cnt_t         cnt_trained;
  ghbp_pkg::idx_t         cnt_raddr;
  ghbp_pkg::idx_t         cnt_waddr;
  logic                   cnt_we;

  assign in_op    = ghbp_pkg::op_t'(in_ch.operation);
  assign in_slot  = ghbp_pkg::slot_of(in_ch.seq_tag, in_ch.piece_num);
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;

  // Load a result now, unless a predict or a train with a checkpoint goes on.
  assign out_load = (state == ST_CNT) ||
                    (accept && (in_op != ghbp_pkg::OP_PREDICT) &&
                     !((in_op == ghbp_pkg::OP_TRAIN) && valid_bits[in_slot]));

  assign out_ch.valid              = out_valid;
  assign out_ch.predict_taken      = out_pred;
  assign out_ch.checkpoint_missing = out_miss;

  // Saturating train of the counter read back for the current request.
  always_comb begin
    cnt_trained = cnt_rdata;
    if (cur_dir) begin
      if (cnt_rdata != ghbp_pkg::CNT_MAX) cnt_trained = cnt_rdata + 2'd1;
    end else begin
      if (cnt_rdata != ghbp_pkg::CNT_MIN) cnt_trained = cnt_rdata - 2'd1;
    end
  end

  // Counter RAM ports: clear sweep or train write-back; read at history or checkpoint.
  always_comb begin
    cnt_raddr = (state == ST_HIST) ? ghbp_pkg::table_index(ck_rdata)
                                   : ghbp_pkg::table_index(history);
    cnt_we    = 1'b0;
    cnt_waddr = cur_idx;
    cnt_wdata = cnt_trained;
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = ghbp_pkg::CNT_MIN;
    end else if (state == ST_CNT && is_train) begin
      cnt_we = 1'b1;
    end
  end

  // Checkpoint the history only when the slot is free.
  assign ck_we = accept && (in_op == ghbp_pkg::OP_PREDICT) && !valid_bits[in_slot];

  ghbp_ram #(
    .WIDTH (ghbp_pkg::CNT_W),
    .DEPTH (ghbp_pkg::TABLE_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ghbp_ram #(
    .WIDTH (ghbp_pkg::HISTORY_BITS),
    .DEPTH (ghbp_pkg::INFLIGHT_SLOTS)
  ) u_ckpt_ram (
    .clk   (clk),
    .we    (ck_we),
    .waddr (in_slot),
    .wdata (history),
    .raddr (in_slot),
    .rdata (ck_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      history   <= '0;
      out_valid <= 1'b0;
      is_train  <= 1'b0;
      for (int i = 0; i < ghbp_pkg::INFLIGHT_SLOTS; i++) begin
        valid_bits[i] <= 1'b0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ghbp_pkg::idx_t'(ghbp_pkg::TABLE_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_dir <= in_ch.taken;
            unique case (in_op)
              ghbp_pkg::OP_PREDICT: begin
                valid_bits[in_slot] <= 1'b1;
                is_train <= 1'b0;
                state    <= ST_CNT;
              end
              ghbp_pkg::OP_SPEC: begin
                history   <= {history[ghbp_pkg::HISTORY_BITS-2:0], in_ch.taken};
                out_pred  <= 1'b0;
                out_miss  <= 1'b0;
              end
              ghbp_pkg::OP_TRAIN: begin
                if (valid_bits[in_slot]) begin
                  is_train <= 1'b1;
                  state    <= ST_HIST;
                end else begin
                  out_pred  <= 1'b0;
                  out_miss  <= 1'b1;
                end
              end
              ghbp_pkg::OP_COMMIT: begin
                valid_bits[in_slot] <= 1'b0;
                out_pred  <= 1'b0;
                out_miss  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_HIST: begin
          // Counter read at the checkpointed history is issued this cycle.
          cur_idx <= ghbp_pkg::table_index(ck_rdata);
          state   <= ST_CNT;
        end
        ST_CNT: begin
          out_pred  <= is_train ? 1'b0 : cnt_rdata[1];
          out_miss  <= 1'b0;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Exercises the global-history branch predictor with directed corner cases and
// with random predict / resolve / train / commit traffic shaped by repeating
// direction patterns. A shadow copy of history, counters and checkpoints
// predicts each response, which is compared in order against the output.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS   = 550;
  localparam int IDLE_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_IN_FLIGHT  = 6;
  localparam ghbp_pkg::cnt_t TAKEN_THRESH = 2'd2;

  typedef struct packed {
    ghbp_pkg::op_t op;
    logic [5:0]    tag;
    logic [1:0]    piece;
    logic          taken;
  } branch_req_t;

  typedef struct packed {
    logic predict_taken;
    logic checkpoint_missing;
  } branch_outcome_t;

  logic clk = 1'b0;
  logic rst;

  ghbp_in_if  in_ch ();
  ghbp_out_if out_ch ();

  global_history_branch_predictor dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the predictor
  ghbp_pkg::hist_t history_shadow;
  ghbp_pkg::cnt_t  counter_shadow [ghbp_pkg::TABLE_ENTRIES];
  ghbp_pkg::hist_t ckpt_history [ghbp_pkg::INFLIGHT_SLOTS];
  bit              ckpt_valid [ghbp_pkg::INFLIGHT_SLOTS];

  branch_req_t     request_q [$];
  branch_outcome_t outcome_q [$];
  int              total_requests;
  int              accepted_count = 0;
  int              error_count = 0;

  function automatic branch_outcome_t resolve_outcome(branch_req_t req);
    branch_outcome_t res;
    int slot;
    int idx;
    res = '0;
    slot = {req.tag, req.piece} % ghbp_pkg::INFLIGHT_SLOTS;
    case (req.op)
      ghbp_pkg::OP_PREDICT: begin
        idx = history_shadow % ghbp_pkg::TABLE_ENTRIES;
        // keep an existing checkpoint; only an empty slot captures history
        if (!ckpt_valid[slot]) begin
          ckpt_history[slot] = history_shadow;
          ckpt_valid[slot] = 1'b1;
        end
        res.predict_taken = (counter_shadow[idx] >= TAKEN_THRESH);
      end
      ghbp_pkg::OP_SPEC: begin
        history_shadow = {history_shadow[ghbp_pkg::HISTORY_BITS-2:0], req.taken};
      end
      ghbp_pkg::OP_TRAIN: begin
        if (!ckpt_valid[slot]) begin
          res.checkpoint_missing = 1'b1;
        end else begin
          idx = ckpt_history[slot] % ghbp_pkg::TABLE_ENTRIES;
          if (req.taken && counter_shadow[idx] != ghbp_pkg::CNT_MAX)
            counter_shadow[idx] = counter_shadow[idx] + 1'b1;
          else if (!req.taken && counter_shadow[idx] != ghbp_pkg::CNT_MIN)
            counter_shadow[idx] = counter_shadow[idx] - 1'b1;
        end
      end
      default: begin
        ckpt_valid[slot] = 1'b0;
      end
    endcase
    return res;
  endfunction

  task automatic queue_request(ghbp_pkg::op_t op, int tag, int piece, bit taken);
    branch_req_t req;
    req.op = op;
    req.tag = tag[5:0];
    req.piece = piece[1:0];
    req.taken = taken;
    request_q.push_back(req);
  endtask

  // Driver: bursts of requests separated by random gaps
  branch_req_t next_req;
  int          burst_left;
  int          gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left <= $urandom_range(1, 24);
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0 || request_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left != 0)
          gap_left <= gap_left - 1;
      end else begin
        next_req = request_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= next_req.op;
        in_ch.seq_tag <= next_req.tag;
        in_ch.piece_num <= next_req.piece;
        in_ch.taken <= next_req.taken;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
          gap_left <= $urandom_range(1, 5);
        end
      end
    end
  end

  // Record the expected response of every accepted request
  branch_req_t taken_req;

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      taken_req.op = ghbp_pkg::op_t'(in_ch.operation);
      taken_req.tag = in_ch.seq_tag;
      taken_req.piece = in_ch.piece_num;
      taken_req.taken = in_ch.taken;
      outcome_q.push_back(resolve_outcome(taken_req));
      accepted_count = accepted_count + 1;
    end
  end

  // Receiver: rotate a stall pattern, swap it for a fresh one now and then
  logic [15:0] stall_pattern;
  int          pattern_age;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_pattern <= 16'hFFFF;
      pattern_age <= 0;
    end else begin
      out_ch.ready <= stall_pattern[0];
      if (pattern_age == 127) begin
        pattern_age <= 0;
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hFFFF;
          1: stall_pattern <= 16'($urandom()) | 16'h0001;
          2: stall_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
          default: stall_pattern <= 16'($urandom() | $urandom());
        endcase
      end else begin
        pattern_age <= pattern_age + 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // Compare responses in order
  branch_outcome_t expected;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        if (error_count < 10)
          $display("ERROR: response with nothing outstanding: pred=%0b missing=%0b",
                   out_ch.predict_taken, out_ch.checkpoint_missing);
        error_count = error_count + 1;
      end else begin
        expected = outcome_q.pop_front();
        if (out_ch.predict_taken !== expected.predict_taken ||
            out_ch.checkpoint_missing !== expected.checkpoint_missing) begin
          if (error_count < 10)
            $display("ERROR: expected pred=%0b missing=%0b, got pred=%0b missing=%0b",
                     expected.predict_taken, expected.checkpoint_missing,
                     out_ch.predict_taken, out_ch.checkpoint_missing);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [8:0] inflight_q [$];
    logic [8:0] branch;
    logic [7:0] key;
    int         roll;
    int         dir_mode;
    int         dir_pos;
    int         mode_left;
    bit         dir;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.seq_tag = '0;
    in_ch.piece_num = '0;
    in_ch.taken = 1'b0;
    out_ch.ready = 1'b0;

    history_shadow = '0;
    foreach (counter_shadow[i]) counter_shadow[i] = ghbp_pkg::CNT_MIN;
    foreach (ckpt_history[i]) ckpt_history[i] = '0;
    foreach (ckpt_valid[i]) ckpt_valid[i] = 1'b0;

    // Train on an empty slot, commit an empty slot
    queue_request(ghbp_pkg::OP_TRAIN, 63, 3, 1'b1);
    queue_request(ghbp_pkg::OP_COMMIT, 63, 3, 1'b0);
    // Predict, then predict again on the occupied slot after history moved
    queue_request(ghbp_pkg::OP_PREDICT, 0, 0, 1'b0);
    queue_request(ghbp_pkg::OP_SPEC, 0, 0, 1'b1);
    queue_request(ghbp_pkg::OP_PREDICT, 0, 0, 1'b1);
    // Saturate the counter upward
    repeat (4) queue_request(ghbp_pkg::OP_TRAIN, 0, 0, 1'b1);
    queue_request(ghbp_pkg::OP_SPEC, 0, 0, 1'b0);
    queue_request(ghbp_pkg::OP_PREDICT, 1, 2, 1'b0);
    repeat (2) queue_request(ghbp_pkg::OP_TRAIN, 1, 2, 1'b1);
    queue_request(ghbp_pkg::OP_PREDICT, 5, 1, 1'b0);
    // Saturate downward
    repeat (3) queue_request(ghbp_pkg::OP_TRAIN, 1, 2, 1'b0);
    queue_request(ghbp_pkg::OP_PREDICT, 5, 1, 1'b1);
    // Train after commit finds no checkpoint
    queue_request(ghbp_pkg::OP_COMMIT, 0, 0, 1'b0);
    queue_request(ghbp_pkg::OP_TRAIN, 0, 0, 1'b0);
    queue_request(ghbp_pkg::OP_COMMIT, 0, 0, 1'b1);
    queue_request(ghbp_pkg::OP_COMMIT, 1, 2, 1'b0);
    queue_request(ghbp_pkg::OP_COMMIT, 5, 1, 1'b0);
    queue_request(ghbp_pkg::OP_PREDICT, 63, 3, 1'b0);
    queue_request(ghbp_pkg::OP_COMMIT, 63, 3, 1'b0);

    // Random traffic: branches predicted, resolved, trained and committed,
    // with directions following short loops so history repeats
    dir_mode = 0;
    dir_pos = 0;
    mode_left = 0;
    while (request_q.size() < 25 + RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        dir_mode = $urandom_range(0, 4);
        mode_left = $urandom_range(20, 80);
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        queue_request(ghbp_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                      $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      end else if (inflight_q.size() == 0 ||
                   (roll < 55 && inflight_q.size() < MAX_IN_FLIGHT)) begin
        case (dir_mode)
          0: dir = 1'b1;
          1: dir = 1'b0;
          2: dir = dir_pos[0];
          3: dir = (dir_pos % 3) != 0;
          default: dir = 1'($urandom_range(0, 1));
        endcase
        dir_pos = dir_pos + 1;
        mode_left = mode_left - 1;
        key = 8'($urandom_range(0, 255));
        queue_request(ghbp_pkg::OP_PREDICT, key[7:2], key[1:0],
                      1'($urandom_range(0, 1)));
        queue_request(ghbp_pkg::OP_SPEC, key[7:2], key[1:0], dir);
        inflight_q.push_back({dir, key});
      end else begin
        branch = inflight_q.pop_front();
        key = branch[7:0];
        roll = $urandom_range(0, 9);
        if (roll != 8)
          queue_request(ghbp_pkg::OP_TRAIN, key[7:2], key[1:0], branch[8]);
        if (roll == 9)
          queue_request(ghbp_pkg::OP_TRAIN, key[7:2], key[1:0], branch[8]);
        // leave the slot occupied now and then
        if (roll != 7)
          queue_request(ghbp_pkg::OP_COMMIT, key[7:2], key[1:0],
                        1'($urandom_range(0, 1)));
        if (roll == 0)
          queue_request(ghbp_pkg::OP_TRAIN, key[7:2], key[1:0],
                        1'($urandom_range(0, 1)));
      end
    end
    total_requests = request_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
